// ----- sv/blc_pkg.sv -----
// Shared types and constants of the button long-press and LED controller.
package blc_pkg;

   // Item kinds carried on req_tuser
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   // Requested tick rate codes
   localparam logic [1:0] RATE_STOPPED = 2'd0;
   localparam logic [1:0] RATE_1S      = 2'd1;
   localparam logic [1:0] RATE_100MS   = 2'd2;
   localparam logic [1:0] RATE_50MS    = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_RESET_HOLD   = 2'd0;
   localparam logic [1:0] CSR_PAIR_HOLD    = 2'd1;
   localparam logic [1:0] CSR_PAIR_SESSION = 2'd2;

   localparam logic [7:0]  RESET_HOLD_DEFAULT   = 8'd20;
   localparam logic [7:0]  PAIR_HOLD_DEFAULT    = 8'd30;
   localparam logic [11:0] PAIR_SESSION_DEFAULT = 12'd2400;

   // Blink pattern lengths
   localparam logic [3:0] RESET_BLINK_LAST = 4'd9;   // 10 phases
   localparam logic [7:0] PAIR_BLINK_LAST  = 8'd19;  // 20 phases

   typedef enum logic [2:0] {
      RST_IDLE  = 3'b001,
      RST_HELD  = 3'b010,
      RST_ARMED = 3'b100
   } reset_stage_type;

   typedef enum logic [2:0] {
      PAIR_NONE    = 3'b001,
      PAIR_DETECT  = 3'b010,
      PAIR_SESSION = 3'b100
   } pair_stage_type;

   typedef struct packed {
      reset_stage_type reset_stage;
      logic [7:0]      reset_count;
      logic [3:0]      blink_phase;
      pair_stage_type  pair_stage;
      logic [7:0]      pair_count;
      logic [7:0]      pair_rehold_count;
      logic [11:0]     session_left;
      logic            power_led;
      logic            pair_led;
      logic [1:0]      rate;
   } state_type;

   typedef struct packed {
      logic [7:0]  reset_hold_ticks;
      logic [7:0]  pair_hold_ticks;
      logic [11:0] pair_session_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       reset_button;
      logic       pair_button;
      logic       pair_allowed;
      logic       test_mode;
      logic       session_ended;
   } item_type;

   typedef struct packed {
      logic       power_led;
      logic       pair_led;
      logic [1:0] tick_rate;
      logic       start_pairing;
      logic       stop_pairing;
      logic       factory_reset;
      logic       test_reset_seen;
      logic       test_pair_seen;
   } result_type;

endpackage

// ----- sv/blc_step.sv -----
// Next-state and result logic for one item of the button/LED controller.
module blc_step (
   input  blc_pkg::state_type  state_i,
   input  blc_pkg::cfg_type    cfg_i,
   input  blc_pkg::item_type   item_i,
   output blc_pkg::state_type  state_o,
   output blc_pkg::result_type result_o
);

   always_comb begin
      blc_pkg::state_type  s;
      blc_pkg::result_type r;
      logic [8:0]          n;
      logic                pressed;
      logic                done;

      s       = state_i;
      r       = '0;
      n       = '0;
      done    = 1'b0;
      pressed = item_i.pair_button & item_i.pair_allowed;

      unique case (item_i.kind)
         blc_pkg::KIND_TICK: begin
            // reset button section, only while no pairing activity
            if (s.pair_stage == blc_pkg::PAIR_NONE) begin
               if (item_i.reset_button) begin
                  if (item_i.test_mode) begin
                     r.test_reset_seen = 1'b1;
                  end else if (s.reset_stage == blc_pkg::RST_IDLE) begin
                     s.reset_stage = blc_pkg::RST_HELD;
                     s.reset_count = '0;
                     s.blink_phase = '0;
                     s.rate        = blc_pkg::RATE_100MS;
                  end else begin
                     n = {1'b0, s.reset_count} + 9'd1;
                     s.reset_count = n[8] ? 8'hFF : n[7:0];
                     s.blink_phase = (s.blink_phase >= blc_pkg::RESET_BLINK_LAST) ?
                                     4'd0 : s.blink_phase + 4'd1;
                     if (n > {1'b0, cfg_i.reset_hold_ticks}) begin
                        s.reset_stage = blc_pkg::RST_ARMED;
                     end
                     if (s.reset_stage == blc_pkg::RST_ARMED) begin
                        s.power_led = !((s.blink_phase == 4'd0) ||
                                        (s.blink_phase == 4'd5) ||
                                        (s.blink_phase == 4'd6));
                     end
                  end
               end else if (s.reset_stage == blc_pkg::RST_HELD) begin
                  // short hold: cancel
                  s.reset_stage = blc_pkg::RST_IDLE;
                  s.reset_count = '0;
                  s.power_led   = 1'b1;
                  s.rate        = blc_pkg::RATE_1S;
               end else if (s.reset_stage == blc_pkg::RST_ARMED) begin
                  // armed and released: fire
                  s.power_led       = 1'b0;
                  s.rate            = blc_pkg::RATE_STOPPED;
                  r.factory_reset   = 1'b1;
                  s.reset_stage     = blc_pkg::RST_IDLE;
                  s.reset_count     = '0;
                  s.blink_phase     = '0;
               end
            end

            if (s.reset_stage != blc_pkg::RST_IDLE) begin
               done = 1'b1;
            end

            if (!done && s.pair_stage != blc_pkg::PAIR_SESSION) begin
               done = 1'b1;
               if (pressed) begin
                  if (item_i.test_mode) begin
                     r.test_pair_seen = 1'b1;
                  end else if (s.pair_stage == blc_pkg::PAIR_NONE) begin
                     s.pair_stage = blc_pkg::PAIR_DETECT;
                     s.pair_count = '0;
                     s.rate       = blc_pkg::RATE_50MS;
                  end else begin
                     n = {1'b0, s.pair_count} + 9'd1;
                     s.pair_count = n[8] ? 8'hFF : n[7:0];
                     if (n > {1'b0, cfg_i.pair_hold_ticks}) begin
                        s.pair_stage        = blc_pkg::PAIR_SESSION;
                        s.pair_count        = '0;
                        s.pair_rehold_count = '0;
                        r.start_pairing     = 1'b1;
                        s.session_left      = cfg_i.pair_session_ticks;
                     end
                  end
               end else if (s.pair_stage == blc_pkg::PAIR_DETECT) begin
                  s.pair_stage = blc_pkg::PAIR_NONE;
                  s.pair_count = '0;
                  s.power_led  = 1'b1;
                  s.rate       = blc_pkg::RATE_1S;
               end
            end

            if (!done) begin
               // running session: re-hold restarts it
               if (pressed) begin
                  n = {1'b0, s.pair_rehold_count} + 9'd1;
                  s.pair_rehold_count = n[8] ? 8'hFF : n[7:0];
                  if (n > {1'b0, cfg_i.pair_hold_ticks}) begin
                     s.pair_rehold_count = '0;
                     r.start_pairing     = 1'b1;
                     s.session_left      = cfg_i.pair_session_ticks;
                  end
               end
               if (!item_i.session_ended) begin
                  s.session_left = s.session_left - 12'd1;
               end
               if (item_i.session_ended || s.session_left == '0) begin
                  s.session_left = '0;
                  s.pair_stage   = blc_pkg::PAIR_NONE;
                  s.pair_count   = '0;
                  s.pair_led     = 1'b1;
                  s.power_led    = 1'b1;
                  s.rate         = blc_pkg::RATE_1S;
                  r.stop_pairing = 1'b1;
               end else begin
                  s.pair_count = (s.pair_count >= blc_pkg::PAIR_BLINK_LAST) ?
                                 8'd0 : s.pair_count + 8'd1;
                  s.pair_led   = !s.pair_count[0] && (s.pair_count > 8'd10);
               end
            end
         end
         blc_pkg::KIND_START: begin
            s.pair_stage        = blc_pkg::PAIR_SESSION;
            s.pair_count        = '0;
            s.pair_rehold_count = '0;
            s.session_left      = cfg_i.pair_session_ticks;
            s.rate              = blc_pkg::RATE_50MS;
         end
         blc_pkg::KIND_STOP: begin
            s.pair_stage        = blc_pkg::PAIR_NONE;
            s.pair_count        = '0;
            s.pair_rehold_count = '0;
            s.session_left      = 12'd1;
            s.rate              = blc_pkg::RATE_1S;
            s.pair_led          = 1'b1;
            s.power_led         = 1'b1;
         end
         default: begin
            // unknown kind: hold state, report as is
         end
      endcase

      r.power_led = s.power_led;
      r.pair_led  = s.pair_led;
      r.tick_rate = s.rate;

      state_o  = s;
      result_o = r;
   end

endmodule

// ----- sv/button_long_press_led_controller_core.sv -----
// Top level of the button long-press and LED controller: state, config and output buffer.
//
// Each accepted req_ transfer is one event: a tick sample of the reset and pairing
// buttons (req_tuser = 0) or an external pairing start (1) or stop (2); kind 3 changes
// nothing. Every input transfer yields exactly one rsp_ transfer with the LED states,
// the requested tick rate and the command pulses (start_pairing, stop_pairing,
// factory_reset) plus the test-mode press reports. The controller state is updated
// in the cycle an item is accepted, by single-pass logic, and the result lands in a
// two-entry output buffer (output register plus skid register), so one item is taken
// every clock cycle as long as the result side drains; the result is registered into the
// output register, or the skid register while that one is full. req_tready drops only
// while both buffer entries are full. Config registers are written through csr_ with
// csr_wen; index 3 is ignored. Write them only while no result is pending.
module button_long_press_led_controller_core (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] reset_button, [1] pair_button, [2] pair_allowed, [3] test_mode,
   // [4] session_ended, [7:5] zero
   input  logic [7:0]  req_tdata,
   // [1:0] kind
   input  logic [1:0]  req_tuser,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] power_led, [1] pair_led, [3:2] tick_rate, [4] start_pairing,
   // [5] stop_pairing, [6] factory_reset, [7] test_reset_seen,
   // [8] test_pair_seen, [15:9] zero
   output logic [15:0] rsp_tdata,
   // config write port
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [11:0] csr_wdata
);

   blc_pkg::state_type  state_ff, state_in;
   blc_pkg::cfg_type    cfg_ff;
   blc_pkg::item_type   item;
   blc_pkg::result_type result_in;
   blc_pkg::result_type out_data_ff, skid_data_ff;
   logic                out_valid_ff, skid_valid_ff;
   logic                req_xfer, rsp_xfer;

   // Unpack the input transfer
   assign item.kind          = req_tuser;
   assign item.reset_button  = req_tdata[0];
   assign item.pair_button   = req_tdata[1];
   assign item.pair_allowed  = req_tdata[2];
   assign item.test_mode     = req_tdata[3];
   assign item.session_ended = req_tdata[4];

   assign req_tready = !skid_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   blc_step u_step (
      .state_i  (state_ff),
      .cfg_i    (cfg_ff),
      .item_i   (item),
      .state_o  (state_in),
      .result_o (result_in)
   );

   // Controller state: advance only on an accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.reset_stage       <= blc_pkg::RST_IDLE;
         state_ff.reset_count       <= '0;
         state_ff.blink_phase       <= '0;
         state_ff.pair_stage        <= blc_pkg::PAIR_NONE;
         state_ff.pair_count        <= '0;
         state_ff.pair_rehold_count <= '0;
         state_ff.session_left      <= '0;
         state_ff.power_led         <= 1'b1;
         state_ff.pair_led          <= 1'b1;
         state_ff.rate              <= blc_pkg::RATE_1S;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_hold_ticks   <= blc_pkg::RESET_HOLD_DEFAULT;
         cfg_ff.pair_hold_ticks    <= blc_pkg::PAIR_HOLD_DEFAULT;
         cfg_ff.pair_session_ticks <= blc_pkg::PAIR_SESSION_DEFAULT;
      end else if (csr_wen) begin
         unique case (csr_addr)
            blc_pkg::CSR_RESET_HOLD:   cfg_ff.reset_hold_ticks   <= csr_wdata[7:0];
            blc_pkg::CSR_PAIR_HOLD:    cfg_ff.pair_hold_ticks    <= csr_wdata[7:0];
            blc_pkg::CSR_PAIR_SESSION: cfg_ff.pair_session_ticks <= csr_wdata;
            default: begin
               // no register there: drop the write
            end
         endcase
      end
   end

   // Output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_xfer) begin
         if (skid_valid_ff) begin
            // skid full means no new transfer this cycle: promote skid
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_xfer;
         end
      end else if (req_xfer) begin
         if (!out_valid_ff) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (req_xfer) begin
            out_data_ff <= result_in;
         end
      end else if (req_xfer) begin
         if (!out_valid_ff) begin
            out_data_ff <= result_in;
         end else begin
            skid_data_ff <= result_in;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        out_data_ff.test_pair_seen,
                        out_data_ff.test_reset_seen,
                        out_data_ff.factory_reset,
                        out_data_ff.stop_pairing,
                        out_data_ff.start_pairing,
                        out_data_ff.tick_rate,
                        out_data_ff.pair_led,
                        out_data_ff.power_led};

   // Skid entry is only ever filled behind a full output register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // A fired factory reset leaves the reset sequence idle and the LED off; a pairing
   // press in the same tick may still change the rate
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && result_in.factory_reset) |=>
         (state_ff.reset_stage == blc_pkg::RST_IDLE) && !state_ff.power_led)
      else $error("factory reset did not settle reset state");

   // Pairing blink phase stays within its 20-phase pattern during a session
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.pair_stage == blc_pkg::PAIR_SESSION) |->
         (state_ff.pair_count <= blc_pkg::PAIR_BLINK_LAST))
      else $error("pairing blink phase out of range");

endmodule
